// ===== rtl/stepper_ramp_step_generator_unit_assert.svh =====
// Assertion macros for the stepper ramp step generator.
`ifndef STEPPER_RAMP_STEP_GENERATOR_UNIT_ASSERT_SVH
`define STEPPER_RAMP_STEP_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SRSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SRSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/srsg_pkg.sv =====
// Shared types and constants of the stepper ramp step generator.
package srsg_pkg;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_MOVE = 2'd1;
  localparam logic [1:0] MODE_SET  = 2'd2;
  localparam logic [1:0] MODE_STOP = 2'd3;

  localparam logic [1:0] REG_FIRST_INTERVAL = 2'd0;
  localparam logic [1:0] REG_MIN_INTERVAL   = 2'd1;
  localparam logic [1:0] REG_MAX_SPEED      = 2'd2;
  localparam logic [1:0] REG_RAMP_NUMERATOR = 2'd3;

  localparam int NUMER_BITS = 50;
  localparam int CFG_DATA_BITS = 50;

  typedef struct packed {
    logic apply;     // take the accepted request
    logic q_load;    // load divider for numerator over interval
    logic sl_load;   // load divider for stopping steps
    logic div_step;  // one restoring division step
    logic decide;    // plan ramp step, load ramp divider
    logic rapply;    // update interval from ramp term
    logic emit;      // load output register
  } srsg_cmd_t;

  typedef struct packed {
    logic recompute;  // accepted request needs a ramp recompute
    logic div_last;   // current division step is the last one
    logic need_ramp;  // planned step needs the ramp division
    logic out_free;   // output register can take a result
  } srsg_status_t;

endpackage

// ===== rtl/srsg_req_if.sv =====
// Request, response and configuration channels.
interface srsg_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic signed [31:0] position;
  modport source (output valid, mode, position, input ready);
  modport sink (input valid, mode, position, output ready);
endinterface

interface srsg_rsp_if;
  logic        valid;
  logic        ready;
  logic        step_pulse;
  logic        clockwise;
  logic signed [31:0] current_position;
  logic        running;
  logic        arrived;
  logic        driver_enable;
  modport source (output valid, step_pulse, clockwise, current_position, running,
                  arrived, driver_enable, input ready);
  modport sink (input valid, step_pulse, clockwise, current_position, running,
                arrived, driver_enable, output ready);
endinterface

interface srsg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [srsg_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/srsg_ctrl.sv =====
// Sequencer for request handling, division passes and result hand-off.
module srsg_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  srsg_pkg::srsg_status_t st,
  output srsg_pkg::srsg_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_QLOAD  = 3'd1;
  localparam logic [2:0] S_SLLOAD = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_RAPPLY = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic [1:0] PH_QUOT = 2'd0;  // numerator over interval
  localparam logic [1:0] PH_STOP = 2'd1;  // stopping steps
  localparam logic [1:0] PH_RAMP = 2'd2;  // ramp term

  logic [2:0] state, state_next;
  logic [1:0] phase, phase_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.apply = 1'b1;
          state_next = st.recompute ? S_QLOAD : S_DONE;
        end
      end
      S_QLOAD: begin
        cmd.q_load = 1'b1;
        phase_next = PH_QUOT;
        state_next = S_DIV;
      end
      S_SLLOAD: begin
        cmd.sl_load = 1'b1;
        phase_next = PH_STOP;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          if (phase == PH_QUOT) state_next = S_SLLOAD;
          else if (phase == PH_STOP) state_next = S_DECIDE;
          else state_next = S_RAPPLY;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        phase_next = PH_RAMP;
        state_next = st.need_ramp ? S_DIV : S_DONE;
      end
      S_RAPPLY: begin
        cmd.rapply = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_QUOT;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

// ===== rtl/srsg_datapath.sv =====
// Motion state, configuration registers, shared divider and output register.
module srsg_datapath #(
  parameter int POSITION_BITS = 32,
  parameter int INTERVAL_FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  srsg_pkg::srsg_cmd_t    cmd,
  output srsg_pkg::srsg_status_t st,
  input  logic [1:0]             req_mode,
  input  logic signed [31:0]     req_position,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [srsg_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                   rsp_ready,
  output logic                   rsp_valid,
  output logic                   rsp_step_pulse,
  output logic                   rsp_clockwise,
  output logic signed [31:0]     rsp_current_position,
  output logic                   rsp_running,
  output logic                   rsp_arrived,
  output logic                   rsp_driver_enable
);

  localparam int P  = POSITION_BITS;
  localparam int F  = INTERVAL_FRAC_BITS;
  localparam int EW = 32 + F;
  localparam int D1 = srsg_pkg::NUMER_BITS + F;
  localparam int SW = (D1 + F > 63) ? D1 + F : 63;
  localparam int CW = (P + 2 > 33) ? P + 2 : 33;
  localparam logic [30:0] SL_MAX = '1;

  // configuration
  logic [31:0] first_interval, min_interval;
  logic [23:0] max_speed_interval;
  logic [srsg_pkg::NUMER_BITS-1:0] ramp_numerator;

  // motion state
  logic signed [P-1:0] pos_now, pos_goal;
  logic signed [31:0]  ramp_step;
  logic [31:0]         ramp_interval, active_interval, elapsed;
  logic                dir_cw, speed_zero, enabled;

  // per-request flags
  logic step_flag, step_dir, arrived_flag;

  // divider: dividend bits leave dd at the top, quotient bits enter at the bottom
  logic [D1-1:0] dd;
  logic [33:0]   rem, dv;
  logic [6:0]    cnt;
  logic          sat, ramp_neg;

  // tick evaluation
  logic [31:0] e_inc;
  logic        step_now;
  assign e_inc = (elapsed == '1) ? elapsed : elapsed + 32'd1;
  assign step_now = (active_interval != '0)
                 && ((EW'(e_inc) << F) >= EW'(active_interval))
                 && (e_inc >= {8'd0, max_speed_interval});

  logic [P+31:0] pin_ext;
  assign pin_ext = {{P{req_position[31]}}, req_position};

  // second pass of stopping steps: first quotient scaled, checked for overflow
  logic [SW-1:0] q_sh, c_sh;
  assign q_sh = SW'(dd) << F;
  assign c_sh = SW'(ramp_interval) << 31;

  logic [30:0] sl;
  always_comb begin
    if (speed_zero) sl = '0;
    else if (ramp_interval == '0 || sat) sl = SL_MAX;
    else sl = dd[30:0];
  end

  logic signed [P:0] gap;
  assign gap = $signed({pos_goal[P-1], pos_goal}) - $signed({pos_now[P-1], pos_now});

  logic signed [CW-1:0] gap_x, ngap_x, sl_x;
  assign gap_x  = CW'(gap);
  assign ngap_x = -gap_x;
  assign sl_x   = $signed({(CW-31)'(0), sl});

  logic               arrive;
  logic signed [31:0] n_new, neg_sl;
  assign neg_sl = -$signed({1'b0, sl});
  assign arrive = (gap == '0) && (sl <= 31'd1);

  always_comb begin
    n_new = ramp_step;
    if (gap > 0) begin
      if (ramp_step > 0) begin
        if (sl_x >= gap_x || !dir_cw) n_new = neg_sl;
      end else if (ramp_step < 0) begin
        if (sl_x < gap_x && dir_cw) n_new = -ramp_step;
      end
    end else if (gap < 0) begin
      if (ramp_step > 0) begin
        if (sl_x >= ngap_x || dir_cw) n_new = neg_sl;
      end else if (ramp_step < 0) begin
        if (sl_x < ngap_x && !dir_cw) n_new = -ramp_step;
      end
    end
  end

  logic [31:0] n_mag;
  logic [33:0] d_mag;
  assign n_mag = n_new[31] ? 32'(-n_new) : 32'(n_new);
  assign d_mag = n_new[31] ? ({n_mag, 2'b00} - 34'd1) : {n_mag, 2'b01};

  // ramp term apply
  logic [32:0] c_sum;
  logic [31:0] c_adj, c_lim;
  logic signed [31:0] n_inc;
  assign c_sum = ramp_neg ? ({1'b0, ramp_interval} + dd[32:0])
                          : ({1'b0, ramp_interval} - dd[32:0]);
  assign c_adj = c_sum[32] ? 32'hFFFF_FFFF : c_sum[31:0];
  assign c_lim = (c_adj < min_interval) ? min_interval : c_adj;
  assign n_inc = (ramp_step == 32'sh7FFF_FFFF) ? ramp_step : ramp_step + 32'sd1;

  // division step
  logic [34:0] r2, r_sub;
  logic        ge;
  assign r2 = {rem, dd[D1-1]};
  assign r_sub = r2 - {1'b0, dv};
  assign ge = r2 >= {1'b0, dv};

  assign st.recompute = (req_mode == srsg_pkg::MODE_MOVE)
                     || (req_mode == srsg_pkg::MODE_TICK && step_now);
  assign st.div_last  = (cnt == 7'd1);
  assign st.need_ramp = !arrive && (n_new != '0);
  assign st.out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_interval <= 32'd256000;
      min_interval <= 32'd256;
      max_speed_interval <= '0;
      ramp_numerator <= srsg_pkg::NUMER_BITS'(500000000);
      pos_now <= '0;
      pos_goal <= '0;
      ramp_step <= '0;
      ramp_interval <= '0;
      active_interval <= '0;
      elapsed <= '0;
      dir_cw <= 1'b0;
      speed_zero <= 1'b1;
      enabled <= 1'b0;
      step_flag <= 1'b0;
      step_dir <= 1'b0;
      arrived_flag <= 1'b0;
      rsp_valid <= 1'b0;
      cnt <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          srsg_pkg::REG_FIRST_INTERVAL: first_interval <= cfg_data[31:0];
          srsg_pkg::REG_MIN_INTERVAL:   min_interval <= cfg_data[31:0];
          srsg_pkg::REG_MAX_SPEED:      max_speed_interval <= cfg_data[23:0];
          srsg_pkg::REG_RAMP_NUMERATOR: ramp_numerator <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.apply) begin
        step_flag <= 1'b0;
        arrived_flag <= 1'b0;
        step_dir <= dir_cw;
        unique case (req_mode)
          srsg_pkg::MODE_TICK: begin
            if (step_now) begin
              step_flag <= 1'b1;
              elapsed <= '0;
              pos_now <= dir_cw ? pos_now + P'(1) : pos_now - P'(1);
            end else begin
              elapsed <= e_inc;
            end
          end
          srsg_pkg::MODE_MOVE: begin
            pos_goal <= pin_ext[P-1:0];
            enabled <= 1'b1;
          end
          srsg_pkg::MODE_SET: begin
            pos_now <= pin_ext[P-1:0];
            pos_goal <= pin_ext[P-1:0];
            ramp_step <= '0;
            active_interval <= '0;
          end
          default: begin
            pos_goal <= pos_now;
            ramp_step <= '0;
            active_interval <= '0;
          end
        endcase
      end

      // numerator scaled by the fraction bits over the interval, full quotient
      if (cmd.q_load) begin
        dd <= D1'(ramp_numerator) << F;
        rem <= '0;
        dv <= {2'b00, ramp_interval};
        cnt <= 7'(D1);
      end

      // first quotient scaled again over the interval, 31 quotient bits
      if (cmd.sl_load) begin
        sat <= q_sh >= c_sh;
        rem <= 34'(q_sh >> 31);
        dd <= {q_sh[30:0], (D1-31)'(0)};
        dv <= {2'b00, ramp_interval};
        cnt <= 7'd31;
      end

      if (cmd.div_step) begin
        rem <= ge ? r_sub[33:0] : r2[33:0];
        dd <= {dd[D1-2:0], ge};
        cnt <= cnt - 7'd1;
      end

      if (cmd.decide) begin
        if (arrive) begin
          active_interval <= '0;
          speed_zero <= 1'b1;
          ramp_step <= '0;
          arrived_flag <= 1'b1;
        end else if (n_new == '0) begin
          ramp_interval <= first_interval;
          active_interval <= first_interval;
          dir_cw <= gap > 0;
          ramp_step <= 32'sd1;
          speed_zero <= 1'b0;
        end else begin
          // start ramp term division 2c / |4n+1|
          ramp_step <= n_new;
          ramp_neg <= n_new[31];
          rem <= '0;
          dd <= {ramp_interval, 1'b0, (D1-33)'(0)};
          dv <= d_mag;
          cnt <= 7'd33;
        end
      end

      if (cmd.rapply) begin
        ramp_interval <= c_lim;
        active_interval <= c_lim;
        ramp_step <= n_inc;
        speed_zero <= 1'b0;
      end

      if (cmd.emit) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  logic [P+31:0] pos_out_ext;
  assign pos_out_ext = {{32{pos_now[P-1]}}, pos_now};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_step_pulse <= step_flag;
      rsp_clockwise <= step_flag ? step_dir : dir_cw;
      rsp_current_position <= pos_out_ext[31:0];
      rsp_running <= active_interval != '0;
      rsp_arrived <= arrived_flag;
      rsp_driver_enable <= enabled;
    end
  end

endmodule

// ===== rtl/stepper_ramp_step_generator_unit.sv =====
// Stepper step generator with trapezoid ramp: top level.
//
// One request is handled at a time and gives one response. A request that
// does not step or move goes straight to the done state, which loads the
// response register once the output register is free, and the block then
// takes the next request. A step or a move runs a ramp recompute through one
// shared restoring divider that yields one quotient bit per cycle: the ramp
// numerator over the interval (NUMER_BITS + INTERVAL_FRAC_BITS quotient bits,
// 58 by default), that quotient over the interval again (31 quotient bits)
// and, when the ramp term is needed, the ramp term (33 quotient bits), which
// is then applied to the interval. The done state loads the response register
// once the output register is free. The next request is taken while a
// response still waits. Configuration is accepted in every cycle and must be
// written only while the block is idle. Intervals are unsigned fixed point
// with INTERVAL_FRAC_BITS fraction bits; positions wrap in POSITION_BITS.
module stepper_ramp_step_generator_unit #(
  parameter int POSITION_BITS = 32,
  parameter int INTERVAL_FRAC_BITS = 8
) (
  input logic clk,
  input logic rst,
  srsg_req_if.sink   req,
  srsg_rsp_if.source rsp,
  srsg_cfg_if.sink   cfg
);

  srsg_pkg::srsg_cmd_t    cmd;
  srsg_pkg::srsg_status_t st;

  assign cfg.ready = 1'b1;

  srsg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  srsg_datapath #(
    .POSITION_BITS      (POSITION_BITS),
    .INTERVAL_FRAC_BITS (INTERVAL_FRAC_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .st                   (st),
    .req_mode             (req.mode),
    .req_position         (req.position),
    .cfg_we               (cfg.valid),
    .cfg_index            (cfg.index),
    .cfg_data             (cfg.data),
    .rsp_ready            (rsp.ready),
    .rsp_valid            (rsp.valid),
    .rsp_step_pulse       (rsp.step_pulse),
    .rsp_clockwise        (rsp.clockwise),
    .rsp_current_position (rsp.current_position),
    .rsp_running          (rsp.running),
    .rsp_arrived          (rsp.arrived),
    .rsp_driver_enable    (rsp.driver_enable)
  );

`include "stepper_ramp_step_generator_unit_assert.svh"

  `SRSG_ASSERT_NOW(a_arrive_idle, rsp.valid && rsp.arrived, !rsp.running, "arrived while running")
  `SRSG_ASSERT_NOW(a_run_enabled, rsp.valid && rsp.running, rsp.driver_enable, "running without enable")
  `SRSG_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready, !req.ready, "ready right after request")
  `SRSG_ASSERT_NEXT(a_emit_valid, cmd.emit, rsp.valid, "response lost")

endmodule
